>>> hw/rtl/iu2x_pkg.sv
// Shared constants and types for the 2x bilinear image upscaler.
// No dependencies; used by all files but the line store.

package iu2x_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_LINE_DEF   = 2048;
	localparam int PIXEL_BITS_DEF = 8;

	// Fixed field widths
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int WEIGHT_W   = 16;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_X_W    = 12;
	localparam int OUT_Y_W    = 13;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Highest source row index (images are at most 4096 rows high)
	localparam logic [ROW_W-1:0] ROW_MAX = '1;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_W_CENT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_SIDE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_CORN  = 3'd4;

	// Register reset values (9/3/3/1 kernel, VGA frame)
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [WEIGHT_W-1:0] W_CENT_RST = 16'd36864;
	localparam logic [WEIGHT_W-1:0] W_SIDE_RST = 16'd12288;
	localparam logic [WEIGHT_W-1:0] W_CORN_RST = 16'd4096;

	// Output row/column phase relative to twice the source index:
	// low = 2n-1, mid = 2n, high = 2n+1
	typedef logic [1:0] phase_t;
	localparam phase_t PH_LOW  = 2'd0;
	localparam phase_t PH_MID  = 2'd1;
	localparam phase_t PH_HIGH = 2'd2;

	// Position flags of the source pixel held in the window stage
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_row;
		logic last_col;
	} ctl_t;

endpackage

>>> hw/rtl/iu2x_if.sv
// Valid/ready channel interfaces of the 2x upscaler: source pixels, results, config writes.
// Depends on iu2x_pkg for default widths.

interface iu2x_pix_if #(
	parameter int PIXEL_BITS = iu2x_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface iu2x_res_if #(
	parameter int PIXEL_BITS = iu2x_pkg::PIXEL_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [iu2x_pkg::OUT_X_W-1:0]  out_x;
	logic [iu2x_pkg::OUT_Y_W-1:0]  out_y;
	logic [PIXEL_BITS-1:0]         value;
	logic                          last;

	modport source (output valid, output out_x, output out_y, output value, output last,
		input ready);
	modport sink   (input valid, input out_x, input out_y, input value, input last,
		output ready);
endinterface

interface iu2x_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [iu2x_pkg::CFG_IDX_W-1:0]  index;
	logic [iu2x_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/iu2x_line_buf.sv
// Line store of the 2x upscaler: one source row, one write and one registered read per cycle.
// Standalone; no package dependencies.

module iu2x_line_buf #(
	parameter int MAX_LINE   = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(MAX_LINE)-1:0] waddr,
	input  logic [PIXEL_BITS-1:0]       wdata,
	input  logic [$clog2(MAX_LINE)-1:0] raddr,
	output logic [PIXEL_BITS-1:0]       rdata
);

	logic [PIXEL_BITS-1:0] mem [MAX_LINE];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; forward a word written to the same slot in this cycle
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/iu2x_window.sv
// Input stage of the 2x upscaler: raster counters, left/upper-left pixels, 2x2 window register.
// Depends on iu2x_pkg, iu2x_if; drives the line store ports.

module iu2x_window #(
	parameter int MAX_LINE   = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	iu2x_pix_if.sink                      pix,
	input  logic [$clog2(MAX_LINE)-1:0]   col_last,
	input  logic [iu2x_pkg::ROW_W-1:0]    row_last,
	// line store
	output logic                          lb_we,
	output logic [$clog2(MAX_LINE)-1:0]   lb_waddr,
	output logic [PIXEL_BITS-1:0]         lb_wdata,
	output logic [$clog2(MAX_LINE)-1:0]   lb_raddr,
	input  logic [PIXEL_BITS-1:0]         lb_rdata,
	// window stage
	input  logic                          done,
	output logic                          s1_valid,
	output iu2x_pkg::ctl_t                ctl_s1,
	output logic [PIXEL_BITS-1:0]         px_s1,
	output logic [PIXEL_BITS-1:0]         lf_s1,
	output logic [PIXEL_BITS-1:0]         up_s1,
	output logic [PIXEL_BITS-1:0]         ul_s1,
	output logic [iu2x_pkg::ROW_W-1:0]    row_s1,
	output logic [$clog2(MAX_LINE)-1:0]   col_s1
);

	localparam int CW = $clog2(MAX_LINE);
	localparam int RW = iu2x_pkg::ROW_W;

	logic [CW-1:0]         col_q, col_d;
	logic [RW-1:0]         row_q, row_d;
	logic [PIXEL_BITS-1:0] left_q, upleft_q;
	logic [PIXEL_BITS-1:0] up, lf, ul;
	logic                  fire;
	iu2x_pkg::ctl_t        ctl;

	assign pix.ready = !s1_valid || done;
	assign fire      = pix.valid && pix.ready;

	// Position of the incoming pixel
	always_comb begin
		ctl.first_row = (row_q == '0);
		ctl.first_col = (col_q == '0);
		ctl.last_row  = (row_q >= row_last);
		ctl.last_col  = (col_q >= col_last);
	end

	// Window neighbors, repeating edge pixels
	always_comb begin
		up = ctl.first_row ? pix.pixel : lb_rdata;
		lf = ctl.first_col ? pix.pixel : left_q;
		if (!ctl.first_row && !ctl.first_col) begin
			ul = upleft_q;
		end else if (!ctl.first_row) begin
			ul = up;
		end else begin
			ul = lf;
		end
	end

	// Advance raster position
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (fire) begin
			if (ctl.last_col) begin
				col_d = '0;
				row_d = ctl.last_row ? '0 : RW'(row_q + 1'b1);
			end else begin
				col_d = CW'(col_q + 1'b1);
			end
		end
	end

	// Store this row for the next one; read ahead the slot of the next pixel
	assign lb_we    = fire;
	assign lb_waddr = col_q;
	assign lb_wdata = pix.pixel;
	assign lb_raddr = col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			upleft_q <= '0;
			s1_valid <= 1'b0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
			if (fire) begin
				left_q   <= pix.pixel;
				upleft_q <= up;
			end
			if (fire) begin
				s1_valid <= 1'b1;
			end else if (done) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Hold the window for the emitter
	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s1 <= ctl;
			px_s1  <= pix.pixel;
			lf_s1  <= lf;
			up_s1  <= up;
			ul_s1  <= ul;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

endmodule

>>> hw/rtl/iu2x_emit.sv
// Result stage of the 2x upscaler: walks the output pixels of one window and blends each one.
// Depends on iu2x_pkg, iu2x_if.

module iu2x_emit #(
	parameter int MAX_LINE   = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s1_valid,
	input  iu2x_pkg::ctl_t                  ctl_s1,
	input  logic [PIXEL_BITS-1:0]           px_s1,
	input  logic [PIXEL_BITS-1:0]           lf_s1,
	input  logic [PIXEL_BITS-1:0]           up_s1,
	input  logic [PIXEL_BITS-1:0]           ul_s1,
	input  logic [iu2x_pkg::ROW_W-1:0]      row_s1,
	input  logic [$clog2(MAX_LINE)-1:0]     col_s1,
	input  logic [iu2x_pkg::WEIGHT_W-1:0]   w_cent,
	input  logic [iu2x_pkg::WEIGHT_W-1:0]   w_side,
	input  logic [iu2x_pkg::WEIGHT_W-1:0]   w_corn,
	output logic                            done,
	iu2x_res_if.source                      res
);

	localparam int P  = PIXEL_BITS;
	localparam int WW = iu2x_pkg::WEIGHT_W;
	localparam int FB = iu2x_pkg::FRAC_BITS;
	localparam int SW = WW + P + 3;
	localparam int XW = iu2x_pkg::OUT_X_W;
	localparam int YW = iu2x_pkg::OUT_Y_W;

	iu2x_pkg::phase_t rstep_q, cstep_q;
	iu2x_pkg::phase_t rstart, cstart, rend, cend, rph, cph;
	logic             adv, row_end, col_end, item_last;
	logic             su, sl, nu, nl;
	logic [P-1:0]     near, side_a, side_b, diag;
	logic [P:0]       side_sum;
	logic [WW+P-1:0]  prod_c, prod_k;
	logic [WW+P:0]    prod_s;
	logic [SW-1:0]    sum;
	logic [SW-FB-1:0] whole;
	logic [P-1:0]     value;
	logic [XW-1:0]    ox;
	logic [YW-1:0]    oy;

	// Window element: u selects the upper row, l the left column
	function automatic logic [P-1:0] pick(input logic u, input logic l,
		input logic [P-1:0] p0, input logic [P-1:0] pl,
		input logic [P-1:0] pu, input logic [P-1:0] pul);
		if (u) begin
			return l ? pul : pu;
		end
		return l ? pl : p0;
	endfunction

	// Output phases covered by this window
	assign rstart = ctl_s1.first_row ? iu2x_pkg::PH_MID : iu2x_pkg::PH_LOW;
	assign cstart = ctl_s1.first_col ? iu2x_pkg::PH_MID : iu2x_pkg::PH_LOW;
	assign rend   = ctl_s1.last_row ? iu2x_pkg::PH_HIGH : iu2x_pkg::PH_MID;
	assign cend   = ctl_s1.last_col ? iu2x_pkg::PH_HIGH : iu2x_pkg::PH_MID;
	assign rph    = 2'(rstart + rstep_q);
	assign cph    = 2'(cstart + cstep_q);

	assign row_end   = (rph == rend);
	assign col_end   = (cph == cend);
	assign item_last = row_end && col_end;
	assign adv       = s1_valid && (!res.valid || res.ready);
	assign done      = adv && item_last;

	// Nearest pixel and neighbor toward the output pixel, per axis
	assign su = (rph == iu2x_pkg::PH_LOW);
	assign nu = (rph == iu2x_pkg::PH_MID) && !ctl_s1.first_row;
	assign sl = (cph == iu2x_pkg::PH_LOW);
	assign nl = (cph == iu2x_pkg::PH_MID) && !ctl_s1.first_col;

	always_comb begin
		near   = pick(su, sl, px_s1, lf_s1, up_s1, ul_s1);
		side_a = pick(su, nl, px_s1, lf_s1, up_s1, ul_s1);
		side_b = pick(nu, sl, px_s1, lf_s1, up_s1, ul_s1);
		diag   = pick(nu, nl, px_s1, lf_s1, up_s1, ul_s1);
	end

	// Blend, drop the fraction, saturate
	assign side_sum = {1'b0, side_a} + {1'b0, side_b};
	assign prod_c   = w_cent * near;
	assign prod_s   = w_side * side_sum;
	assign prod_k   = w_corn * diag;
	assign sum      = SW'(prod_c) + SW'(prod_s) + SW'(prod_k);
	assign whole    = sum[SW-1:FB];
	assign value    = (|whole[SW-FB-1:P]) ? {P{1'b1}} : whole[P-1:0];

	// Output coordinates: twice the source index plus phase minus one
	assign ox = XW'({XW'(col_s1), 1'b0}) + XW'(cph) - XW'(1);
	assign oy = YW'({row_s1, 1'b0}) + YW'(rph) - YW'(1);

	// Step through columns, then rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstep_q   <= '0;
			cstep_q   <= '0;
			res.valid <= 1'b0;
		end else begin
			if (adv) begin
				if (col_end) begin
					cstep_q <= '0;
					rstep_q <= row_end ? '0 : 2'(rstep_q + 1'b1);
				end else begin
					cstep_q <= 2'(cstep_q + 1'b1);
				end
			end
			if (adv) begin
				res.valid <= 1'b1;
			end else if (res.ready) begin
				res.valid <= 1'b0;
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (adv) begin
			res.out_x <= ox;
			res.out_y <= oy;
			res.value <= value;
			res.last  <= item_last;
		end
	end

endmodule

>>> hw/rtl/image_upscale_2x_bilinear.sv
// An accepted pixel is registered in the window stage, its words in the result register.
// Throughput: one result word per cycle from a single blend unit while res is not stalled;
// each source pixel holds it for all its words: 4 inside the image, 1 to 9 at the edges.
// A new pixel is taken in the cycle the last word of the previous one is issued.
// Reset clears counters, handshakes and edge pixels and loads the 640x480, 9/3/3/1 defaults;
// the line store is not cleared, and each row reads back what the row above wrote.

module image_upscale_2x_bilinear #(
	parameter int MAX_LINE   = iu2x_pkg::MAX_LINE_DEF,
	parameter int PIXEL_BITS = iu2x_pkg::PIXEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	iu2x_pix_if.sink    pix,
	iu2x_res_if.source  res,
	iu2x_cfg_if.sink    cfg
);

	localparam int CW  = $clog2(MAX_LINE);
	localparam int LCW = (CW > iu2x_pkg::WIDTH_W) ? CW : iu2x_pkg::WIDTH_W;
	localparam int HW  = iu2x_pkg::HEIGHT_W;
	localparam int RW  = iu2x_pkg::ROW_W;

	logic [iu2x_pkg::WIDTH_W-1:0]  width_q, width_m1;
	logic [HW-1:0]                 height_q, height_m1;
	logic [iu2x_pkg::WEIGHT_W-1:0] w_cent_q, w_side_q, w_corn_q;
	logic [LCW-1:0]                width_m1_l;
	logic [CW-1:0]                 col_last;
	logic [RW-1:0]                 row_last;

	logic                  lb_we;
	logic [CW-1:0]         lb_waddr, lb_raddr;
	logic [PIXEL_BITS-1:0] lb_wdata, lb_rdata;

	logic                  s1_valid, done;
	iu2x_pkg::ctl_t        ctl_s1;
	logic [PIXEL_BITS-1:0] px_s1, lf_s1, up_s1, ul_s1;
	logic [RW-1:0]         row_s1;
	logic [CW-1:0]         col_s1;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= iu2x_pkg::WIDTH_RST;
			height_q <= iu2x_pkg::HEIGHT_RST;
			w_cent_q <= iu2x_pkg::W_CENT_RST;
			w_side_q <= iu2x_pkg::W_SIDE_RST;
			w_corn_q <= iu2x_pkg::W_CORN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				iu2x_pkg::REG_WIDTH:  width_q  <= cfg.data[iu2x_pkg::WIDTH_W-1:0];
				iu2x_pkg::REG_HEIGHT: height_q <= cfg.data[HW-1:0];
				iu2x_pkg::REG_W_CENT: w_cent_q <= cfg.data;
				iu2x_pkg::REG_W_SIDE: w_side_q <= cfg.data;
				iu2x_pkg::REG_W_CORN: w_corn_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Last column and row index: zero counts as one, clamp to the line store and row limit
	assign width_m1   = (width_q == '0) ? '0 : width_q - 1'b1;
	assign width_m1_l = LCW'(width_m1);
	assign col_last   = (width_m1_l > LCW'(MAX_LINE - 1)) ? CW'(MAX_LINE - 1) : CW'(width_m1_l);
	assign height_m1  = (height_q == '0) ? '0 : height_q - 1'b1;
	assign row_last   = (height_m1 > HW'(iu2x_pkg::ROW_MAX)) ? iu2x_pkg::ROW_MAX
		: height_m1[RW-1:0];

	iu2x_line_buf #(
		.MAX_LINE   (MAX_LINE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_buf (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_waddr),
		.wdata (lb_wdata),
		.raddr (lb_raddr),
		.rdata (lb_rdata)
	);

	iu2x_window #(
		.MAX_LINE   (MAX_LINE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.col_last (col_last),
		.row_last (row_last),
		.lb_we    (lb_we),
		.lb_waddr (lb_waddr),
		.lb_wdata (lb_wdata),
		.lb_raddr (lb_raddr),
		.lb_rdata (lb_rdata),
		.done     (done),
		.s1_valid (s1_valid),
		.ctl_s1   (ctl_s1),
		.px_s1    (px_s1),
		.lf_s1    (lf_s1),
		.up_s1    (up_s1),
		.ul_s1    (ul_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1)
	);

	iu2x_emit #(
		.MAX_LINE   (MAX_LINE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.ctl_s1   (ctl_s1),
		.px_s1    (px_s1),
		.lf_s1    (lf_s1),
		.up_s1    (up_s1),
		.ul_s1    (ul_s1),
		.row_s1   (row_s1),
		.col_s1   (col_s1),
		.w_cent   (w_cent_q),
		.w_side   (w_side_q),
		.w_corn   (w_corn_q),
		.done     (done),
		.res      (res)
	);

	// An accepted pixel is held in the window stage next cycle
	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> s1_valid)
		else $error("accepted pixel not held in window stage");

	// Finishing a window issues a word flagged last
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (res.valid && res.last))
		else $error("window finished without a last word");

	// A new result word comes only from a held window
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(s1_valid))
		else $error("result word without a window");

endmodule

>>> dv/tb_image_upscale_2x_bilinear.sv
`timescale 1ns / 1ps
// Self-checking bench for the 2x bilinear upscaler: drives source pixels, config writes and
// result back-pressure, and compares every result word with an in-bench pixel-window model.
// Depends on iu2x_pkg, the iu2x channel interfaces and image_upscale_2x_bilinear.

module tb_image_upscale_2x_bilinear;
	import iu2x_pkg::*;

	localparam int PIX_W        = PIXEL_BITS_DEF;
	localparam int PIX_MAX      = (1 << PIX_W) - 1;
	localparam int LINE_DEPTH   = MAX_LINE_DEF;
	localparam int ROW_LIMIT    = 4096;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 16;
	localparam int RANDOM_ITEMS = 120;

	// 8/2/2/3 over 15 kernel in 16-bit fractions
	localparam logic [WEIGHT_W-1:0] HARD_CENT = 16'd34953;
	localparam logic [WEIGHT_W-1:0] HARD_SIDE = 16'd8738;
	localparam logic [WEIGHT_W-1:0] HARD_CORN = 16'd13107;

	typedef logic [PIX_W-1:0] pix_t;
	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [OUT_X_W-1:0] x;
		logic [OUT_Y_W-1:0] y;
		pix_t               value;
		logic               last;
	} out_word_t;

	typedef struct {
		pix_t value;
		bit   wait_drain;
	} src_word_t;

	logic clk;
	logic arst_n;

	iu2x_pix_if #(.PIXEL_BITS(PIX_W)) pix_ch ();
	iu2x_res_if #(.PIXEL_BITS(PIX_W)) res_ch ();
	iu2x_cfg_if                       cfg_ch ();

	image_upscale_2x_bilinear #(
		.MAX_LINE   (LINE_DEPTH),
		.PIXEL_BITS (PIX_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Model copy of the registers and the window state
	logic [WIDTH_W-1:0]  m_width;
	logic [HEIGHT_W-1:0] m_height;
	logic [WEIGHT_W-1:0] m_w_cent, m_w_side, m_w_corn;
	pix_t                m_line [LINE_DEPTH];
	pix_t                m_left, m_upleft;
	int                  m_col, m_row;

	out_word_t pending_outputs [$];
	src_word_t source_pixels [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int mismatch_count;
	int cycle_count;

	always #6 clk = ~clk;

	// Mix the 2x2 window toward output pixel (oy, ox); win[u][l], u = row above, l = left
	function automatic pix_t blend_window(input logic [1:0][1:0][PIX_W-1:0] win,
		input int oy, input int ox, input int r, input int c);
		int   sy, sx, ny, nx;
		bit   su, sl, nu, nl;
		u64_t acc;
		sy = oy >> 1;
		sx = ox >> 1;
		ny = (oy & 1) ? sy + 1 : sy - 1;
		nx = (ox & 1) ? sx + 1 : sx - 1;
		if (ny < 0) ny = 0;
		if (ny > r) ny = r;
		if (nx < 0) nx = 0;
		if (nx > c) nx = c;
		su = (sy < r);
		sl = (sx < c);
		nu = (ny < r);
		nl = (nx < c);
		acc = u64_t'(m_w_cent) * win[su][sl]
			+ u64_t'(m_w_side) * (u64_t'(win[su][nl]) + win[nu][sl])
			+ u64_t'(m_w_corn) * win[nu][nl];
		acc = acc >> FRAC_BITS;
		return (acc > PIX_MAX) ? pix_t'(PIX_MAX) : acc[PIX_W-1:0];
	endfunction

	// Queue every output word whose window closes at this source pixel, then advance
	function automatic void upscale_pixel(input pix_t px);
		int   w, h, c, r, slot, oy, ox, oy0, oy1, ox0, ox1;
		bit   last_col, last_row;
		pix_t up, lf, ul;
		logic [1:0][1:0][PIX_W-1:0] win;
		out_word_t word;
		w = (m_width == 0) ? 1 : ((m_width > LINE_DEPTH) ? LINE_DEPTH : int'(m_width));
		h = (m_height == 0) ? 1 : ((m_height > ROW_LIMIT) ? ROW_LIMIT : int'(m_height));
		c = m_col;
		r = m_row;
		slot = c % LINE_DEPTH;
		last_col = (c >= w - 1);
		last_row = (r >= h - 1);

		// clamp the window at the top and left image borders
		up = (r > 0) ? m_line[slot] : px;
		lf = (c > 0) ? m_left : px;
		if (r > 0 && c > 0)
			ul = m_upleft;
		else if (r > 0)
			ul = up;
		else
			ul = lf;
		win[0][0] = px;
		win[0][1] = lf;
		win[1][0] = up;
		win[1][1] = ul;

		oy0 = (r > 0) ? 2 * r - 1 : 0;
		oy1 = last_row ? 2 * r + 1 : 2 * r;
		ox0 = (c > 0) ? 2 * c - 1 : 0;
		ox1 = last_col ? 2 * c + 1 : 2 * c;
		for (oy = oy0; oy <= oy1; oy++) begin
			for (ox = ox0; ox <= ox1; ox++) begin
				word.x     = OUT_X_W'(ox);
				word.y     = OUT_Y_W'(oy);
				word.value = blend_window(win, oy, ox, r, c);
				word.last  = (oy == oy1 && ox == ox1);
				pending_outputs.push_back(word);
			end
		end

		m_upleft = up;
		m_left = px;
		m_line[slot] = px;
		if (last_col) begin
			m_col = 0;
			m_row = last_row ? 0 : r + 1;
		end else begin
			m_col = c + 1;
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_WIDTH:  m_width  = data[WIDTH_W-1:0];
			REG_HEIGHT: m_height = data[HEIGHT_W-1:0];
			REG_W_CENT: m_w_cent = data[WEIGHT_W-1:0];
			REG_W_SIDE: m_w_side = data[WEIGHT_W-1:0];
			REG_W_CORN: m_w_corn = data[WEIGHT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic pix_t rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return pix_t'(PIX_MAX);
			default: return pix_t'($urandom_range(PIX_MAX));
		endcase
	endfunction

	// Pixel driver: hold a word until taken, insert gaps, hold drain-marked words
	always @(posedge clk or negedge arst_n) begin : drive_pixels
		src_word_t word;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (source_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct
				&& !(source_pixels[0].wait_drain
					&& (pix_ch.valid || pending_outputs.size() != 0))) begin
				word = source_pixels.pop_front();
				pix_ch.valid <= 1'b1;
				pix_ch.pixel <= word.value;
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Result back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor: track config writes, predict on accepted pixels, check result words
	always @(posedge clk or negedge arst_n) begin : check_results
		out_word_t want;
		if (!arst_n) begin
			m_width  = WIDTH_RST;
			m_height = HEIGHT_RST;
			m_w_cent = W_CENT_RST;
			m_w_side = W_SIDE_RST;
			m_w_corn = W_CORN_RST;
			m_left   = '0;
			m_upleft = '0;
			m_col    = 0;
			m_row    = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				apply_reg(cfg_ch.index, cfg_ch.data);
			if (pix_ch.valid && pix_ch.ready)
				upscale_pixel(pix_ch.pixel);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_outputs.size() == 0) begin
					mismatch_count++;
					$display("%0t: stray word, expected none, got x=%0d y=%0d v=%0d l=%0b",
						$time, res_ch.out_x, res_ch.out_y, res_ch.value, res_ch.last);
				end else begin
					want = pending_outputs.pop_front();
					if (res_ch.out_x !== want.x || res_ch.out_y !== want.y
						|| res_ch.value !== want.value || res_ch.last !== want.last) begin
						mismatch_count++;
						$display("%0t: mismatch, expected x=%0d y=%0d v=%0d l=%0b",
							$time, want.x, want.y, want.value, want.last,
							", got x=%0d y=%0d v=%0d l=%0b",
							res_ch.out_x, res_ch.out_y, res_ch.value, res_ch.last);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result words outstanding", $time,
				pending_outputs.size());
			$display("image_upscale_2x_bilinear test failed");
			$finish;
		end
	end

	task automatic push_px(input pix_t value, input bit wait_drain = 1'b0);
		src_word_t word;
		word.value = value;
		word.wait_drain = wait_drain;
		source_pixels.push_back(word);
	endtask

	// Wait until every pixel is taken and every expected word has come back
	task automatic settle();
		do @(negedge clk);
		while (source_pixels.size() != 0 || pix_ch.valid || pending_outputs.size() != 0);
	endtask

	// Call right after a rising edge; returns at the edge that takes the word
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk);
		while (!cfg_ch.ready);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] height,
		input logic [CFG_DATA_W-1:0] w_cent, input logic [CFG_DATA_W-1:0] w_side,
		input logic [CFG_DATA_W-1:0] w_corn);
		settle();
		@(posedge clk);
		put_reg(REG_WIDTH, width);
		put_reg(REG_HEIGHT, height);
		put_reg(REG_W_CENT, w_cent);
		put_reg(REG_W_SIDE, w_side);
		put_reg(REG_W_CORN, w_corn);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int items, w, h, k, i;
		logic [WEIGHT_W-1:0] wc, ws, wk;

		clk = 1'b0;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_WIDTH;
		cfg_ch.data = '0;
		tx_idle_pct = 8;
		rx_idle_pct = 51;
		mismatch_count = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: start a 640-wide row
		push_px(8'd0);
		push_px(8'd255);
		push_px(8'd128);
		// shrink the width under the current column: it becomes the row's last
		configure(16'd3, 16'd480, W_CENT_RST, W_SIDE_RST, W_CORN_RST);
		push_px(8'd77);
		push_px(8'd255);
		push_px(8'd0);
		push_px(8'd17);
		// cut the height under the current row: it becomes the image's last
		configure(16'd3, 16'd2, W_CENT_RST, W_SIDE_RST, W_CORN_RST);
		push_px(8'd200);
		push_px(8'd1);
		push_px(8'd254);
		// weight sum far above one saturates; one-pixel image
		configure(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_px(8'd255);
		push_px(8'd1);
		// zero size acts as one pixel, zero weights give black
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		push_px(8'd255);
		push_px(8'd170);
		// hard kernel on a small image, one word held until the block drains
		configure(16'd2, 16'd3, HARD_CENT, HARD_SIDE, HARD_CORN);
		push_px(8'd85);
		push_px(8'd170);
		push_px(8'd0, 1'b1);
		push_px(8'd255);
		push_px(8'd255);
		push_px(8'd0);

		// random small images, idle pattern switched by thirds
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if (items >= 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (items >= RANDOM_ITEMS / 3) begin
				tx_idle_pct = 51;
				rx_idle_pct = 8;
			end
			w = ($urandom_range(4) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
			h = $urandom_range(4, 1);
			case ($urandom_range(3))
				0, 1: begin
					k = $urandom_range(16);
					wc = WEIGHT_W'((int'(W_CENT_RST) * (16 - k) + int'(HARD_CENT) * k) / 16);
					ws = WEIGHT_W'((int'(W_SIDE_RST) * (16 - k) + int'(HARD_SIDE) * k) / 16);
					wk = WEIGHT_W'((int'(W_CORN_RST) * (16 - k) + int'(HARD_CORN) * k) / 16);
				end
				2: begin
					wc = WEIGHT_W'($urandom);
					ws = WEIGHT_W'($urandom);
					wk = WEIGHT_W'($urandom);
				end
				default: begin
					wc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					ws = $urandom_range(1) ? 16'hFFFF : WEIGHT_W'($urandom);
					wk = $urandom_range(1) ? 16'h0000 : WEIGHT_W'($urandom);
				end
			endcase
			configure(16'(w), 16'(h), wc, ws, wk);
			for (i = 0; i < w * h; i++)
				push_px(rand_pixel(), $urandom_range(39) == 0);
			items += w * h;
		end

		// sizes above the limits: a few pixels of a saturated row, then cut the row short
		configure(16'h0FFF, 16'h1FFF, W_CENT_RST, W_SIDE_RST, W_CORN_RST);
		for (i = 0; i < 4; i++)
			push_px(rand_pixel());
		configure(16'd2, 16'd1, HARD_CENT, HARD_SIDE, HARD_CORN);
		push_px(rand_pixel());

		// drain, then watch for stray words
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d expected result words never arrived", $time,
				pending_outputs.size());
		end
		if (mismatch_count == 0)
			$display("image_upscale_2x_bilinear test passed");
		else
			$display("image_upscale_2x_bilinear test failed");
		$finish;
	end

endmodule
